[design/adc_level_ladder_classifier_core_defines.svh]
// assertion macros for the adc level ladder classifier checker
// depends on nothing; the using module must have clk and arst_n in scope
`ifndef ADC_LEVEL_LADDER_CLASSIFIER_CORE_DEFINES_SVH
`define ADC_LEVEL_LADDER_CLASSIFIER_CORE_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define ALC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ALC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/alc_pkg.sv]
// shared constants, types and ladder table of the adc level ladder classifier
// no dependencies
package alc_pkg;

	// frame and sample geometry
	localparam int FRAME_SAMPLES = 10;
	localparam int CHANNELS      = 8;
	localparam int SAMPLE_BITS   = 12;
	localparam int SAMPLE_MAX    = (2 ** SAMPLE_BITS) - 1;

	// port widths
	localparam int SAMPLE_W = 12;
	localparam int CHAN_W   = 3;
	localparam int LEVEL_W  = 4;
	localparam int LIMIT_W  = 19;
	localparam int SUM_O_W  = 16;
	localparam int DEV_O_W  = 19;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

	// internal widths, sized for the largest possible values
	localparam int SUM_MAX = FRAME_SAMPLES * SAMPLE_MAX;
	localparam int DEV_MAX = FRAME_SAMPLES * FRAME_SAMPLES * SAMPLE_MAX;
	localparam int CNT_W   = (FRAME_SAMPLES > 2) ? $clog2(FRAME_SAMPLES) : 1;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	localparam int DEV_W   = $clog2(DEV_MAX + 1);

	// voltage ladder: v < t is tested as s * vref_centi < t_centi * n * full_scale
	localparam int LADDER_STEPS = 9;
	localparam int VREF_CENTI   = 330;
	localparam int ADC_FULL     = 4096;
	localparam int SCALE        = FRAME_SAMPLES * ADC_FULL;
	localparam int LADDER_TOP   = 290;
	localparam int LHS_MAX      = (SUM_MAX * VREF_CENTI > LADDER_TOP * SCALE) ?
	                              SUM_MAX * VREF_CENTI : LADDER_TOP * SCALE;
	localparam int LHS_W        = $clog2(LHS_MAX + 1);

	localparam int LADDER_CV [LADDER_STEPS] = '{15, 50, 90, 115, 140, 180, 210, 230, 290};

	// threshold k of the ladder in comparison units
	function automatic logic [LHS_W-1:0] ladder_th(input int k);
		return LHS_W'(LADDER_CV[k] * SCALE);
	endfunction

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PASS,
		ST_FINISH
	} alc_state_t;

	// controller to datapath
	typedef struct packed {
		logic store;
		logic pass_clr;
		logic pass_step;
		logic load;
	} alc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic last;
		logic pass_last;
		logic out_free;
	} alc_status_t;

endpackage

[design/alc_ctrl.sv]
// frame sequencer of the adc level ladder classifier
// depends on alc_pkg
module alc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  alc_pkg::alc_status_t status,
	output alc_pkg::alc_cmd_t    cmd
);
	import alc_pkg::*;

	alc_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.hit && status.last) begin
					state_d = ST_PASS;
				end
			end
			ST_PASS: begin
				if (status.pass_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands and input stall
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				cmd.store    = in_valid && status.hit;
				cmd.pass_clr = in_valid && status.hit && status.last;
			end
			ST_PASS: begin
				cmd.pass_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[design/alc_datapath.sv]
// frame store, sums, deviation accumulator, ladder compare and result register
// depends on alc_pkg
module alc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [alc_pkg::LIMIT_W-1:0]   cfg_wr_data,
	input  logic [alc_pkg::SAMPLE_W-1:0]  sample,
	input  logic [alc_pkg::CHAN_W-1:0]    channel,
	input  alc_pkg::alc_cmd_t             cmd,
	output alc_pkg::alc_status_t          status,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [alc_pkg::LEVEL_W-1:0]   bias_level,
	output logic                          stable,
	output logic [alc_pkg::SUM_O_W-1:0]   sample_sum,
	output logic [alc_pkg::DEV_O_W-1:0]   deviation_sum
);
	import alc_pkg::*;

	logic [SAMPLE_BITS-1:0] frame_mem [FRAME_SAMPLES];
	logic [SAMPLE_BITS-1:0] x;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;
	logic [SUM_W-1:0]       sum_q;
	logic [DEV_W-1:0]       dev_q;
	logic [LIMIT_W-1:0]     limit_q;
	logic [LEVEL_W-1:0]     level_q;
	logic                   out_valid_q;
	logic [SUM_W-1:0]       scaled;
	logic [SUM_W-1:0]       abs_diff;
	logic [LHS_W-1:0]       lhs;
	logic                   is_stable;
	logic [LEVEL_W-1:0]     new_level;
	logic [31:0]            sum_ext;
	logic [31:0]            dev_ext;

	assign x = SAMPLE_BITS'(sample);

	// status back to the sequencer
	assign status.hit       = (32'(channel) == 32'(CHANNELS - 1));
	assign status.last      = (count_q == CNT_W'(FRAME_SAMPLES - 1));
	assign status.pass_last = (idx_q == CNT_W'(FRAME_SAMPLES - 1));
	assign status.out_free  = !out_valid_q || !out_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// frame store
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			frame_mem[count_q] <= x;
		end
	end

	// fill count and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.load) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.store) begin
			sum_q <= sum_q + SUM_W'(x);
			if (!status.last) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// one absolute deviation term per step
	assign scaled   = SUM_W'(frame_mem[idx_q]) * SUM_W'(FRAME_SAMPLES);
	assign abs_diff = (scaled >= sum_q) ? (scaled - sum_q) : (sum_q - scaled);

	// deviation accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			dev_q <= '0;
		end else if (cmd.pass_clr) begin
			idx_q <= '0;
			dev_q <= '0;
		end else if (cmd.pass_step) begin
			idx_q <= idx_q + 1'b1;
			dev_q <= dev_q + DEV_W'(abs_diff);
		end
	end

	// stability test and ladder classification
	assign is_stable = (32'(dev_q) < 32'(limit_q));
	assign lhs       = LHS_W'(sum_q) * LHS_W'(VREF_CENTI);

	always_comb begin
		new_level = level_q;
		for (int k = LADDER_STEPS - 1; k >= 1; k--) begin
			if (lhs > ladder_th(k - 1) && lhs < ladder_th(k)) begin
				new_level = LEVEL_W'(k);
			end
		end
		if (lhs < ladder_th(0)) begin
			new_level = '0;
		end
	end

	// level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cmd.load && is_stable) begin
			level_q <= new_level;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, saturated to the port widths
	assign sum_ext = 32'(sum_q);
	assign dev_ext = 32'(dev_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bias_level    <= is_stable ? new_level : level_q;
			stable        <= is_stable;
			sample_sum    <= (sum_ext > 32'(2 ** SUM_O_W - 1)) ? '1 : SUM_O_W'(sum_ext);
			deviation_sum <= (dev_ext > 32'(2 ** DEV_O_W - 1)) ? '1 : DEV_O_W'(dev_ext);
		end
	end

	assign out_valid = out_valid_q;

endmodule

[design/adc_level_ladder_classifier_core.sv]
// top level of the adc level ladder classifier
// depends on alc_pkg, alc_ctrl and alc_datapath
//
// input channel: sample and channel with in_valid / in_stall; an item moves at
// a clock edge with valid high and stall low. only items of the last channel
// slot are kept; the others are taken and dropped.
// every tenth kept item closes a frame and yields one result item on the output
// channel (bias_level, stable, sample_sum, deviation_sum) with out_valid /
// out_stall; all other items yield nothing.
// throughput: one item per cycle inside a frame; the closing item is followed
// by a deviation pass (one stored sample per cycle through the shared
// accumulator) and a result state, during which in_stall is high.
// out_valid is registered and rises at the edge that leaves the result state.
// a stalled result is held in the output register; the next frame may be
// collected meanwhile, and the following result waits in the result state
// until the register is free. reset (arst_n low) empties the frame, clears
// the level to 0, drops any pending result and sets stability_limit to 1000.
// cfg_wr_en writes stability_limit; the user must see that it is written
// only while no frame result is pending; the block does not enforce it.
module adc_level_ladder_classifier_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [alc_pkg::LIMIT_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [alc_pkg::SAMPLE_W-1:0]  sample,
	input  logic [alc_pkg::CHAN_W-1:0]    channel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [alc_pkg::LEVEL_W-1:0]   bias_level,
	output logic                          stable,
	output logic [alc_pkg::SUM_O_W-1:0]   sample_sum,
	output logic [alc_pkg::DEV_O_W-1:0]   deviation_sum
);
	import alc_pkg::*;

	alc_cmd_t    cmd;
	alc_status_t status;

	// sequencer
	alc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	alc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.sample        (sample),
		.channel       (channel),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.bias_level    (bias_level),
		.stable        (stable),
		.sample_sum    (sample_sum),
		.deviation_sum (deviation_sum)
	);

endmodule

[design/alc_checker.sv]
// port level checks of the adc level ladder classifier, bound to the top level
// depends on alc_pkg and adc_level_ladder_classifier_core_defines.svh
`include "adc_level_ladder_classifier_core_defines.svh"

module alc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [alc_pkg::LEVEL_W-1:0]   bias_level,
	input logic [alc_pkg::SUM_O_W-1:0]   sample_sum,
	input logic [alc_pkg::DEV_O_W-1:0]   deviation_sum
);
	import alc_pkg::*;

	// a stalled result stays offered
	`ALC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")

	// the level never leaves the ladder
	`ALC_ASSERT(a_level_range, out_valid |-> 32'(bias_level) < 32'(LADDER_STEPS + 1), "bias level out of range")

	// sums stay within what a full frame can give
	`ALC_ASSERT(a_sum_range, out_valid |-> 32'(sample_sum) <= 32'(SUM_MAX) && 32'(deviation_sum) <= 32'(DEV_MAX), "frame sums out of range")

	// no result is offered in the cycle after a reset edge
	`ALC_ASSERT_RST(a_reset_idle, !arst_n |=> !out_valid, "result valid in reset")

endmodule

bind adc_level_ladder_classifier_core alc_checker u_alc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.bias_level    (bias_level),
	.sample_sum    (sample_sum),
	.deviation_sum (deviation_sum)
);

[bench/tb.sv]
// testbench for adc_level_ladder_classifier_core: frame sums, deviation, stability and level ladder
// depends on alc_pkg and the core; every frame result is checked against an in-bench classifier
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import alc_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned DRAIN_LIMIT   = 4000;
	localparam int unsigned HOLD_CYCLES   = 200;
	localparam int unsigned MAX_WAIT      = 8;
	localparam int unsigned PRINT_CAP     = 100;

	localparam logic [CHAN_W-1:0]  KEPT_SLOT = CHAN_W'(CHANNELS - 1);
	localparam logic [LIMIT_W-1:0] LIMIT_TOP = LIMIT_W'(409500);

	// one frame result as the output channel carries it
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               steady;
		logic [SUM_O_W-1:0] total;
		logic [DEV_O_W-1:0] spread;
	} frame_result_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wr_data = '0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] sample      = '0;
	logic [CHAN_W-1:0]   channel     = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [LEVEL_W-1:0]  bias_level;
	logic                stable;
	logic [SUM_O_W-1:0]  sample_sum;
	logic [DEV_O_W-1:0]  deviation_sum;

	// classifier state kept by the bench
	logic [SAMPLE_W-1:0] frame_buf [FRAME_SAMPLES];
	int unsigned         frame_fill  = 0;
	longint unsigned     frame_total = 0;
	logic [LEVEL_W-1:0]  level_now   = '0;
	logic [LIMIT_W-1:0]  limit_now   = LIMIT_RESET;
	frame_result_t       frame_results_due [$];
	frame_result_t       due_result;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned rx_wait        = 0;
	logic        rx_hold        = 1'b0;
	bit          rx_idle        = 1'b1;
	bit          tx_idle        = 1'b1;

	adc_level_ladder_classifier_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.channel      (channel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bias_level   (bias_level),
		.stable       (stable),
		.sample_sum   (sample_sum),
		.deviation_sum(deviation_sum)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// ladder position of a frame sum, compared in whole centivolt units
	function automatic logic [LEVEL_W-1:0] ladder_level(longint unsigned total,
			logic [LEVEL_W-1:0] held);
		longint unsigned volts;
		longint unsigned unit;
		volts = total * VREF_CENTI;
		unit  = FRAME_SAMPLES * ADC_FULL;
		if (volts < LADDER_CV[0] * unit)
			return '0;
		for (int k = 1; k < LADDER_STEPS; k++) begin
			if (volts > LADDER_CV[k-1] * unit && volts < LADDER_CV[k] * unit)
				return LEVEL_W'(k);
		end
		// on a threshold or above the top step the level is held
		return held;
	endfunction

	// collect kept-slot samples and work out the result when a frame closes
	task automatic track_sample(logic [SAMPLE_W-1:0] x, logic [CHAN_W-1:0] ch);
		longint unsigned dev;
		longint unsigned scaled;
		logic            steady;
		frame_result_t   res;
		if (ch != KEPT_SLOT)
			return;
		frame_buf[frame_fill] = x;
		frame_total += x;
		frame_fill++;
		if (frame_fill < FRAME_SAMPLES)
			return;
		dev = 0;
		for (int i = 0; i < FRAME_SAMPLES; i++) begin
			scaled = longint'(FRAME_SAMPLES) * frame_buf[i];
			dev += (scaled >= frame_total) ? scaled - frame_total : frame_total - scaled;
		end
		steady = dev < limit_now;
		if (steady)
			level_now = ladder_level(frame_total, level_now);
		res.level  = level_now;
		res.steady = steady;
		res.total  = (frame_total > 64'hFFFF) ? '1 : SUM_O_W'(frame_total);
		res.spread = (dev > 64'h7FFFF) ? '1 : DEV_O_W'(dev);
		frame_results_due.push_back(res);
		frame_fill  = 0;
		frame_total = 0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (frame_results_due.size() == 0) begin
				report("result with nothing due, bias_level", bias_level, 0);
			end else begin
				due_result = frame_results_due.pop_front();
				if (bias_level !== due_result.level)
					report("bias_level", bias_level, due_result.level);
				if (stable !== due_result.steady)
					report("stable", stable, due_result.steady);
				if (sample_sum !== due_result.total)
					report("sample_sum", sample_sum, due_result.total);
				if (deviation_sum !== due_result.spread)
					report("deviation_sum", deviation_sum, due_result.spread);
			end
		end
	end

	// receiver: random wait per result item, plus an optional long hold-off
	always @(posedge clk) begin
		int unsigned next_wait;
		if (out_valid === 1'b1 && !out_stall)
			next_wait = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		else if (out_valid === 1'b1 && rx_wait != 0)
			next_wait = rx_wait - 1;
		else
			next_wait = rx_wait;
		rx_wait   <= next_wait;
		out_stall <= rx_hold || next_wait != 0;
	end

	// offer one item after a random gap and wait until it is taken
	task automatic send_item(logic [SAMPLE_W-1:0] x, logic [CHAN_W-1:0] ch);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= x;
		channel  <= ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_sample(x, ch);
	endtask

	task automatic send_noise(int unsigned count);
		repeat (count) send_item(SAMPLE_W'($urandom), CHAN_W'($urandom_range(0, CHANNELS - 2)));
	endtask

	// frame whose sum is exactly total, samples differing by at most one
	task automatic send_sum_frame(int unsigned total, int unsigned noise_pct);
		int unsigned base;
		int unsigned extra;
		base  = total / FRAME_SAMPLES;
		extra = total % FRAME_SAMPLES;
		for (int i = 0; i < FRAME_SAMPLES; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_noise(1);
			send_item(SAMPLE_W'(base + (i < extra)), KEPT_SLOT);
		end
	endtask

	// frame scattered around a centre, clipped to the sample range
	task automatic send_spread_frame(int center, int spread, int unsigned noise_pct);
		int v;
		for (int i = 0; i < FRAME_SAMPLES; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_noise(1);
			v = center + int'($urandom_range(0, 2 * spread)) - spread;
			if (v < 0)
				v = 0;
			if (v > SAMPLE_MAX)
				v = SAMPLE_MAX;
			send_item(SAMPLE_W'(v), KEPT_SLOT);
		end
	endtask

	// zero and full scale in turn: the widest deviation a frame can have
	task automatic send_alternating_frame();
		for (int i = 0; i < FRAME_SAMPLES; i++)
			send_item((i % 2) ? '1 : '0, KEPT_SLOT);
	endtask

	// stop offering, wait for every due result, then let the pipeline settle
	task automatic drain_results();
		int unsigned n;
		in_valid <= 1'b0;
		n = 0;
		while (frame_results_due.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(logic [LIMIT_W-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_now = value;
	endtask

	// full-scale frame with every other slot in between, then the widest frame
	task automatic test_extremes();
		for (int i = 0; i < FRAME_SAMPLES; i++) begin
			if (i < CHANNELS - 1)
				send_item((i % 2) ? '1 : '0, CHAN_W'(i));
			send_item('1, KEPT_SLOT);
		end
		send_alternating_frame();
	endtask

	// sums on both sides of every threshold; an exact hit is out of reach for whole sums
	task automatic test_ladder_edges();
		int unsigned unit;
		int unsigned cut;
		unit = FRAME_SAMPLES * ADC_FULL;
		set_limit(LIMIT_RESET);
		for (int k = 0; k < LADDER_STEPS; k++) begin
			cut = LADDER_CV[k] * unit / VREF_CENTI;
			send_sum_frame(cut, 10);
			send_sum_frame(cut + 1, 10);
		end
		// above the ladder the level is held, both high and low
		send_sum_frame(FRAME_SAMPLES * SAMPLE_MAX, 0);
		send_sum_frame(0, 0);
		send_sum_frame(38000, 10);
		repeat (4) send_sum_frame($urandom_range(0, FRAME_SAMPLES * SAMPLE_MAX), 20);
	endtask

	// deviation just under, on and over the limit, and the limit extremes
	task automatic test_stability_limit();
		set_limit('0);
		send_sum_frame(20000, 0);
		set_limit(LIMIT_W'(1));
		send_sum_frame(20000, 0);
		send_sum_frame(20001, 0);
		set_limit(LIMIT_W'(18));
		send_sum_frame(20001, 0);
		set_limit(LIMIT_W'(19));
		send_sum_frame(20001, 0);
		set_limit(LIMIT_TOP);
		send_alternating_frame();
		set_limit(LIMIT_W'($urandom_range(0, 409500)));
		send_spread_frame($urandom_range(0, SAMPLE_MAX), 2000, 0);
	endtask

	// receiver holds off while the sender keeps going, so the core fills and stalls
	task automatic test_output_hold();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (4) send_spread_frame($urandom_range(0, SAMPLE_MAX), 2, 0);
		drain_results();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// phases of random frames, each under its own limit and idling pattern
	task automatic test_random_traffic();
		int unsigned pick;
		int          center;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 4))
				0: set_limit('0);
				1: set_limit(LIMIT_TOP);
				2: set_limit(LIMIT_RESET);
				3: set_limit(LIMIT_W'($urandom_range(0, 2000)));
				default: set_limit(LIMIT_W'($urandom_range(0, 409500)));
			endcase
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			repeat (10) begin
				pick = $urandom_range(0, 99);
				if ($urandom_range(0, 9) == 0)
					center = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
				else
					center = $urandom_range(0, SAMPLE_MAX);
				if (pick < 60)
					send_spread_frame(center, $urandom_range(0, 3), 15);
				else if (pick < 85)
					send_spread_frame(center, $urandom_range(4, 60), 15);
				else
					send_spread_frame(ADC_FULL / 2, ADC_FULL / 2, 15);
			end
			// leave a part frame open across the next register write
			repeat ($urandom_range(0, 4))
				send_item(SAMPLE_W'($urandom), CHAN_W'($urandom));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_ladder_edges();
		test_stability_limit();
		test_output_hold();
		test_random_traffic();
		drain_results();
		if (frame_results_due.size() != 0)
			report("results never seen, count", frame_results_due.size(), 0);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
